// ===== hw/rtl/cdfbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdfbs_pkg
// Shared types and constants of the inverse-cdf binary search sampler.
// ----------------------------------------------------------------------------
package cdfbs_pkg;

   localparam int SUM_W  = 42;   // prefix sums, 11 integer and 31 fraction bits
   localparam int PROB_W = 32;   // probability, 1 integer and 31 fraction bits
   localparam int RAND_W = 31;   // uniform value, 31 fraction bits
   localparam int IDX_W  = 11;   // sample index on the result channel
   localparam int CSR_W  = 4;    // qubit count register

   localparam logic [SUM_W-1:0] SUM_MAX       = {SUM_W{1'b1}};
   localparam logic [CSR_W-1:0] QUBITS_RESET  = CSR_W'(10);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic              op;
      logic [PROB_W-1:0] probability;
      logic [RAND_W-1:0] random_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] sample_index;
      logic             retry;
   } rsp_type;

   // start of one sample in the search unit
   typedef struct packed {
      logic              search;   // table complete, run the binary search
      logic              reject;   // table incomplete, answer with retry
      logic [RAND_W-1:0] random_value;
   } srch_cmd_type;

   // finished sample leaving the search unit
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] sample_index;
      logic             retry;
   } srch_res_type;

endpackage : cdfbs_pkg
`default_nettype wire

// ===== hw/rtl/cdfbs_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdfbs_table
// Cumulative probability table: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cdfbs_table #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 42
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] table_mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : cdfbs_table
`default_nettype wire

// ===== hw/rtl/cdfbs_loader.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdfbs_loader
// Running prefix sum over loaded probabilities with saturation, and the
// fill position of the cumulative table.
// ----------------------------------------------------------------------------
module cdfbs_loader
   import cdfbs_pkg::*;
#(
   parameter int MAX_QUBITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic                  load,
   input  wire logic [PROB_W-1:0]     probability,
   input  wire logic [MAX_QUBITS:0]   dim,
   output      logic                  wr_en,
   output      logic [MAX_QUBITS-1:0] wr_addr,
   output      logic [SUM_W-1:0]      wr_data,
   output      logic [MAX_QUBITS:0]   load_pos,
   output      logic                  loaded
);

   localparam int DIM_W  = MAX_QUBITS + 1;
   localparam int ADDR_W = MAX_QUBITS;

   logic [DIM_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             wrap;
   logic [DIM_W-1:0] base_pos;
   logic [SUM_W-1:0] base_sum;
   logic [SUM_W:0]   add;
   logic [SUM_W-1:0] sat_sum;

   // a load after a full table starts a new one
   assign wrap     = (pos_ff >= dim);
   assign base_pos = wrap ? '0 : pos_ff;
   assign base_sum = wrap ? '0 : sum_ff;
   assign add      = {1'b0, base_sum} + (SUM_W + 1)'(probability);
   assign sat_sum  = add[SUM_W] ? SUM_MAX : add[SUM_W-1:0];

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (clear) begin
         pos_in = '0;
         sum_in = '0;
      end else if (load) begin
         pos_in = base_pos + DIM_W'(1);
         sum_in = sat_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   assign wr_en    = load && !clear;
   assign wr_addr  = base_pos[ADDR_W-1:0];
   assign wr_data  = sat_sum;
   assign load_pos = pos_ff;
   assign loaded   = (pos_ff == dim);

endmodule : cdfbs_loader
`default_nettype wire

// ===== hw/rtl/cdfbs_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdfbs_search
// Binary search sequencer: one table probe and one compare per cycle,
// with the next probe address chosen from both possible halves.
// ----------------------------------------------------------------------------
module cdfbs_search
   import cdfbs_pkg::*;
#(
   parameter int MAX_QUBITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire srch_cmd_type          cmd,
   input  wire logic [MAX_QUBITS:0]   dim,
   input  wire logic                  out_free,
   input  wire logic [SUM_W-1:0]      rd_data,
   output      logic [MAX_QUBITS-1:0] rd_addr,
   output      logic                  busy,
   output      srch_res_type          res
);

   localparam int DIM_W  = MAX_QUBITS + 1;
   localparam int ADDR_W = MAX_QUBITS;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  lo_ff, lo_in;
   logic [DIM_W-1:0]  hi_ff, hi_in;
   logic [DIM_W-1:0]  mid_ff, mid_in;
   logic [RAND_W-1:0] rand_ff, rand_in;
   logic              reject_ff, reject_in;

   logic             gt;
   logic [DIM_W:0]   sum_a, sum_b;
   logic [DIM_W-1:0] mid_a, mid_b;
   logic [DIM_W-1:0] span_a, span_b;
   logic [DIM_W-1:0] addr_a, addr_b;
   logic [DIM_W-1:0] init_hi, init_mid, init_addr;
   logic [DIM_W-1:0] next_lo, next_hi, next_mid;
   logic             done;

   // rd_data holds the cumulative value at mid_ff
   assign gt = (rd_data > SUM_W'(rand_ff));

   // lower half (lo, mid) and upper half (mid, hi) prepared in parallel
   assign sum_a  = (DIM_W + 1)'(lo_ff) + (DIM_W + 1)'(mid_ff);
   assign sum_b  = (DIM_W + 1)'(mid_ff) + (DIM_W + 1)'(hi_ff);
   assign mid_a  = sum_a[DIM_W:1];
   assign mid_b  = sum_b[DIM_W:1];
   assign span_a = mid_ff - lo_ff;
   assign span_b = hi_ff - mid_ff;
   assign addr_a = mid_a - DIM_W'(1);
   assign addr_b = mid_b - DIM_W'(1);

   assign next_lo  = gt ? lo_ff : mid_ff;
   assign next_hi  = gt ? mid_ff : hi_ff;
   assign next_mid = gt ? mid_a : mid_b;
   assign done     = gt ? (span_a <= DIM_W'(1)) : (span_b <= DIM_W'(1));

   assign init_hi   = dim + DIM_W'(1);
   assign init_mid  = init_hi >> 1;
   assign init_addr = init_mid - DIM_W'(1);

   always_comb begin
      if (state_ff == ST_SEARCH) begin
         rd_addr = gt ? addr_a[ADDR_W-1:0] : addr_b[ADDR_W-1:0];
      end else begin
         rd_addr = init_addr[ADDR_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      rand_in   = rand_ff;
      reject_in = reject_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.search) begin
               lo_in     = '0;
               hi_in     = init_hi;
               mid_in    = init_mid;
               rand_in   = cmd.random_value;
               reject_in = 1'b0;
               state_in  = ST_SEARCH;
            end else if (cmd.reject) begin
               lo_in     = '0;
               reject_in = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_SEARCH: begin
            lo_in  = next_lo;
            hi_in  = next_hi;
            mid_in = next_mid;
            if (done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      rand_ff   <= rand_in;
      reject_ff <= reject_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign res.valid        = (state_ff == ST_FINISH) && out_free;
   assign res.sample_index = IDX_W'(lo_ff);
   assign res.retry        = reject_ff || (lo_ff == dim);

endmodule : cdfbs_search
`default_nettype wire

// ===== hw/rtl/cdf_binary_search_sampler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdf_binary_search_sampler_unit
// Inverse-cdf sampler over a loaded probability diagonal.
// ----------------------------------------------------------------------------
// Load requests (op 0) bring the probabilities in index order, held off
// while a sample is in progress, and build a saturating prefix-sum table of
// 2^MAX_QUBITS entries in a single-port-read memory. A sample request (op 1)
// returns the largest index whose cumulative value is at most the random
// value, with retry set when that index equals the dimension or when the
// table is not fully loaded (index 0). A sample occupies the block from
// acceptance to the next possible request with up to q + 1 table probes, q
// being the effective qubit count, one per cycle, set by the memory read
// and compare loop of the search; the result is then handed off and the
// search unit returns to idle. Some searches end one probe early, and a
// stalled result holds the block for as long as the stall lasts. A sample
// on an incomplete table skips the search and goes straight to the hand-off.
// Writing the qubit register discards the loaded table. There is no memory
// clearing pass after reset.
// ----------------------------------------------------------------------------
module cdf_binary_search_sampler_unit
   import cdfbs_pkg::*;
#(
   parameter int MAX_QUBITS = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire req_type          req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      rsp_type          rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [CSR_W-1:0] csr_write_data
);

   localparam int DIM_W  = MAX_QUBITS + 1;
   localparam int ADDR_W = MAX_QUBITS;

   logic [CSR_W-1:0]  qubits_ff, qubits_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0]  dim;
   logic              req_accept;
   logic              load;
   logic              loaded;
   logic [DIM_W-1:0]  load_pos;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [SUM_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [SUM_W-1:0]  rd_data;
   logic              search_busy;
   logic              out_free;
   srch_cmd_type      cmd;
   srch_res_type      res;

   // qubit count above the table size acts as the table size
   always_comb begin
      if (int'(qubits_ff) > MAX_QUBITS) begin
         dim = DIM_W'(1) << MAX_QUBITS;
      end else begin
         dim = DIM_W'(1) << qubits_ff;
      end
   end

   assign req_stall  = search_busy;
   assign req_accept = req_valid && !req_stall;
   assign load       = req_accept && (req_data.op == OP_LOAD);

   assign cmd.search       = req_accept && (req_data.op == OP_SAMPLE) && loaded;
   assign cmd.reject       = req_accept && (req_data.op == OP_SAMPLE) && !loaded;
   assign cmd.random_value = req_data.random_value;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   cdfbs_loader #(
      .MAX_QUBITS (MAX_QUBITS)
   ) u_loader (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_write_enable),
      .load        (load),
      .probability (req_data.probability),
      .dim         (dim),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .load_pos    (load_pos),
      .loaded      (loaded)
   );

   cdfbs_table #(
      .ADDR_W (ADDR_W),
      .DATA_W (SUM_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cdfbs_search #(
      .MAX_QUBITS (MAX_QUBITS)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .dim      (dim),
      .out_free (out_free),
      .rd_data  (rd_data),
      .rd_addr  (rd_addr),
      .busy     (search_busy),
      .res      (res)
   );

   always_comb begin
      qubits_in    = csr_write_enable ? csr_write_data : qubits_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res.valid) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.sample_index = res.sample_index;
         rsp_data_in.retry        = res.retry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qubits_ff    <= QUBITS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         qubits_ff    <= qubits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fill position never runs past the dimension
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      load_pos <= dim)
      else $error("load position beyond dimension");

   // a retry carries either the dimension or zero for an incomplete table
   a_retry_index: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.retry |->
         (res.sample_index == IDX_W'(dim)) || (res.sample_index == '0))
      else $error("retry with unexpected index");

   // a started sample keeps the block busy until its result is handed off
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.search || cmd.reject |=> search_busy)
      else $error("sample accepted but search unit idle");

endmodule : cdf_binary_search_sampler_unit
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the inverse-cdf binary search sampler. Probability
// loads and sample requests go in over a valid/stall channel while a local
// prefix-sum table with its own binary search predicts every sample result.
// Directed cases cover the edge values; random tables of many sizes, a
// receiver hold-off and one full 1024-entry table follow.
// ----------------------------------------------------------------------------
module testbench;
   import cdfbs_pkg::*;

   localparam int          TB_MAX_QUBITS = 10;
   localparam int          TABLE_DEPTH   = 1 << TB_MAX_QUBITS;
   localparam int          SETTLE_CYCLES = 24;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          RANDOM_TARGET = 400;
   localparam longint      CYCLE_LIMIT   = 1_000_000;
   localparam logic [31:0] P_ONE         = 32'h8000_0000;
   localparam logic [30:0] R_TOP         = {RAND_W{1'b1}};

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   req_type          req_data         = '0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [CSR_W-1:0] csr_write_data   = '0;

   // local copy of the sampler state
   logic [SUM_W-1:0] model_cdf [TABLE_DEPTH];
   logic [SUM_W-1:0] model_sum;
   int unsigned      model_loaded;
   logic [CSR_W-1:0] model_qubits;

   rsp_type     expected_samples [$];
   int unsigned mismatch_count = 0;
   int unsigned samples_checked = 0;
   int unsigned items_sent = 0;
   longint      cycle_count = 0;
   int unsigned tx_calm = 0;
   int unsigned rx_calm = 0;
   int unsigned rx_stall_left = 0;
   int unsigned rx_hold_left = 0;
   logic        hold_token = 1'b0;
   logic        hold_seen = 1'b0;

   cdf_binary_search_sampler_unit #(
      .MAX_QUBITS (TB_MAX_QUBITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, now and then a calm stretch
   function automatic int unsigned pick_gap(inout int unsigned calm_left);
      int unsigned roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned table_size();
      int unsigned q;
      q = (model_qubits > TB_MAX_QUBITS) ? TB_MAX_QUBITS : model_qubits;
      return 1 << q;
   endfunction

   function automatic req_type make_req(logic op, logic [31:0] prob, logic [30:0] rnd);
      req_type rq;
      rq.op           = op;
      rq.probability  = prob;
      rq.random_value = rnd;
      return rq;
   endfunction

   function automatic void predict_request(input req_type rq);
      int unsigned    size_now;
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    mid;
      logic [SUM_W:0] wide;
      rsp_type        res;
      size_now = table_size();
      if (rq.op == OP_LOAD) begin
         // a load after a complete table starts a new one
         if (model_loaded >= size_now) begin
            model_loaded = 0;
            model_sum    = '0;
         end
         wide      = {1'b0, model_sum} + (SUM_W+1)'(rq.probability);
         model_sum = (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_W-1:0];
         model_cdf[model_loaded] = model_sum;
         model_loaded++;
      end else begin
         if (model_loaded != size_now) begin
            res.sample_index = '0;
            res.retry        = 1'b1;
         end else begin
            lo = 0;
            hi = size_now + 1;
            while (hi - lo > 1) begin
               mid = (lo + hi) >> 1;
               if (model_cdf[mid-1] > SUM_W'(rq.random_value)) hi = mid;
               else lo = mid;
            end
            res.sample_index = IDX_W'(lo);
            res.retry        = (lo == size_now);
         end
         expected_samples.insert(expected_samples.size(), res);
      end
   endfunction

   task automatic send_request(input req_type rq);
      int unsigned gap;
      req_data  <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_request(rq);
      items_sent++;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      // loads give no result, so let the last ones finish
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_qubits(input logic [CSR_W-1:0] value);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      model_qubits = value;
      model_sum    = '0;
      model_loaded = 0;
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_table(input int unsigned count, input int unsigned style);
      longint      share;
      int unsigned prob;
      share = 64'h1_0000_0000 / table_size();
      if (share > P_ONE) share = P_ONE;
      repeat (count) begin
         case (style)
            0: prob = $urandom_range(0, 32'(share));
            1: prob = ($urandom_range(0, 3) == 0) ? $urandom_range(0, P_ONE) : 0;
            2: prob = $urandom_range(0, P_ONE);
            default: prob = P_ONE / table_size();
         endcase
         send_request(make_req(OP_LOAD, prob, 31'($urandom)));
      end
   endtask

   // random values aimed at the table boundaries and at both extremes, as well as uniform ones
   task automatic draw_samples(input int unsigned count);
      int unsigned      roll;
      int unsigned      k;
      logic [SUM_W-1:0] boundary;
      logic [30:0]      rnd;
      repeat (count) begin
         roll = $urandom_range(0, 9);
         rnd  = 31'($urandom);
         if (roll >= 4 && roll < 8 && model_loaded == table_size()) begin
            k        = $urandom_range(1, table_size());
            boundary = model_cdf[k-1];
            if (boundary <= SUM_W'(R_TOP)) begin
               rnd = boundary[30:0];
               if (boundary != 0 && $urandom_range(0, 1)) rnd = rnd - 1;
            end
         end else if (roll >= 8) begin
            rnd = roll[0] ? R_TOP : '0;
         end
         send_request(make_req(OP_SAMPLE, $urandom, rnd));
      end
   endtask

   task automatic test_reset_default();
      // default is ten qubits, nothing loaded yet
      send_request(make_req(OP_SAMPLE, '0, R_TOP));
      send_request(make_req(OP_LOAD, P_ONE, '0));
      send_request(make_req(OP_SAMPLE, '0, '0));
   endtask

   task automatic test_single_entry();
      write_qubits(4'd0);
      send_request(make_req(OP_LOAD, P_ONE, '0));
      send_request(make_req(OP_SAMPLE, '0, '0));
      send_request(make_req(OP_SAMPLE, 32'hFFFF_FFFF, R_TOP));
      // reload with zero: every value lands on the dimension
      send_request(make_req(OP_LOAD, '0, R_TOP));
      send_request(make_req(OP_SAMPLE, '0, '0));
   endtask

   task automatic test_zero_steps();
      write_qubits(4'd2);
      send_request(make_req(OP_LOAD, '0, '0));
      send_request(make_req(OP_LOAD, 32'h4000_0000, '0));
      send_request(make_req(OP_LOAD, '0, '0));
      send_request(make_req(OP_LOAD, 32'h4000_0000, '0));
      send_request(make_req(OP_SAMPLE, '0, '0));
      send_request(make_req(OP_SAMPLE, '0, 31'h3FFF_FFFF));
      send_request(make_req(OP_SAMPLE, '0, 31'h4000_0000));
      send_request(make_req(OP_SAMPLE, '0, R_TOP));
   endtask

   task automatic test_short_sum();
      write_qubits(4'd1);
      send_request(make_req(OP_LOAD, 32'd1, '0));
      send_request(make_req(OP_LOAD, 32'd1, '0));
      send_request(make_req(OP_SAMPLE, '0, R_TOP));
      send_request(make_req(OP_SAMPLE, '0, '0));
      send_request(make_req(OP_SAMPLE, '0, 31'd1));
   endtask

   task automatic test_register_clears();
      write_qubits(4'd1);
      send_request(make_req(OP_SAMPLE, '0, '0));
      write_qubits(4'd12);
      send_request(make_req(OP_SAMPLE, '0, '0));
   endtask

   task automatic test_random_tables();
      int unsigned q;
      int unsigned roll;
      while (items_sent < RANDOM_TARGET) begin
         q = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
         write_qubits(CSR_W'(q));
         repeat ($urandom_range(1, 4)) begin
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
               load_table(table_size(), $urandom_range(0, 3));
               draw_samples($urandom_range(3, 12));
            end else if (roll < 9) begin
               // broken sequence: a random number of loads, often a partial table whose samples get retry
               load_table($urandom_range(0, table_size()), $urandom_range(0, 3));
               draw_samples($urandom_range(1, 4));
            end else begin
               draw_samples($urandom_range(1, 3));
            end
         end
      end
   endtask

   task automatic test_receiver_hold();
      write_qubits(4'd3);
      load_table(8, 0);
      hold_token <= ~hold_token;
      draw_samples(40);
   endtask

   task automatic test_largest_table();
      write_qubits(4'($urandom_range(11, 15)));
      load_table(TABLE_DEPTH, $urandom_range(0, 3));
      draw_samples(40);
      write_qubits(4'd10);
      draw_samples(2);
   endtask

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen    <= hold_token;
         rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rx_hold_left--;
      end else if (rx_stall_left > 0) begin
         rsp_stall <= 1'b1;
         rx_stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) rx_stall_left = pick_gap(rx_calm);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected result: sample_index %0d retry %0b",
                   rsp_data.sample_index, rsp_data.retry);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp_data.sample_index !== want.sample_index) begin
               $error("sample_index: expected %0d, actual %0d",
                      want.sample_index, rsp_data.sample_index);
               mismatch_count++;
            end
            if (rsp_data.retry !== want.retry) begin
               $error("retry: expected %0b, actual %0b", want.retry, rsp_data.retry);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      model_qubits = QUBITS_RESET;
      model_sum    = '0;
      model_loaded = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_default();
      test_single_entry();
      test_zero_steps();
      test_short_sum();
      test_register_clears();
      test_random_tables();
      test_receiver_hold();
      test_largest_table();
      wait_until_drained();

      $display("testbench: %0d requests sent, %0d sample results checked", items_sent,
               samples_checked);
      $display("testbench: qubit settings 0 to 8, 10 and above the table size, partial and full tables up to 1024 entries");
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== cdf_binary_search_sampler_unit.f =====
hw/rtl/cdfbs_pkg.sv
hw/rtl/cdfbs_table.sv
hw/rtl/cdfbs_loader.sv
hw/rtl/cdfbs_search.sv
hw/rtl/cdf_binary_search_sampler_unit.sv
tb/testbench.sv
